// ===== src/tte_pkg.sv =====
// Shared types and codes of the topology table engine.
`timescale 1ns / 1ps
`default_nettype none

package tte_pkg;

    localparam logic [1:0] KIND_HEADER   = 2'd0;
    localparam logic [1:0] KIND_SELECTOR = 2'd1;
    localparam logic [1:0] KIND_TICK     = 2'd2;

    localparam logic [2:0] STATUS_HEADER_DONE = 3'd0;
    localparam logic [2:0] STATUS_INSERTED    = 3'd1;
    localparam logic [2:0] STATUS_REFRESHED   = 3'd2;
    localparam logic [2:0] STATUS_DROPPED     = 3'd3;
    localparam logic [2:0] STATUS_TICK_DONE   = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] originator;
        logic [15:0] seq_number;
        logic [15:0] hold_ticks;
        logic [31:0] selector_address;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] removed_count;
        logic [6:0] occupancy;
    } t_out_item;

    typedef struct packed {
        logic        valid;
        logic [31:0] dest;
        logic [31:0] last_hop;
        logic [15:0] seq;
        logic [31:0] expiry;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic clear_entry;
        logic hit;
        logic empty;
    } t_eval;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== src/tte_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/tte_eval.sv =====
// Per-entry match, purge and free-slot evaluation of one table entry.
`timescale 1ns / 1ps
`default_nettype none

module tte_eval (
    input  wire logic [1:0]     i_kind,
    input  wire tte_pkg::t_entry i_entry,
    input  wire logic [31:0]    i_originator,
    input  wire logic [15:0]    i_seq_number,
    input  wire logic [31:0]    i_selector_address,
    input  wire logic [31:0]    i_latched_originator,
    input  wire logic [31:0]    i_time,
    output tte_pkg::t_eval      o_eval
);

    import tte_pkg::*;

    logic stale_seq;
    logic expired;

    always_comb begin
        stale_seq = (i_entry.last_hop == i_originator) && (i_entry.seq < i_seq_number);
        expired   = i_entry.expiry < i_time;
        o_eval.clear_entry = i_entry.valid &&
                             (((i_kind == KIND_HEADER) && stale_seq) ||
                              ((i_kind == KIND_TICK) && expired));
        o_eval.hit   = i_entry.valid && (i_kind == KIND_SELECTOR) &&
                       (i_entry.dest == i_selector_address) &&
                       (i_entry.last_hop == i_latched_originator);
        o_eval.empty = !i_entry.valid;
    end

endmodule

`default_nettype wire

// ===== src/topology_table_engine_core.sv =====
// Top level of the topology table engine: sequencer around the entry memory.
//
//   Channel | Signals                  | Payload
//   --------+--------------------------+---------------------
//   input   | i_valid / o_ready        | i_data  (t_in_item)
//   result  | o_valid / i_ready        | o_data  (t_out_item)
//
// Each item scans the entry memory once, one read per cycle, and a selector
// writes its entry after the scan.
// After reset a clearing pass writes every entry invalid.
// A result waits in the output register; the next item is taken meanwhile, and
// its own result waits until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module topology_table_engine_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire tte_pkg::t_in_item i_data,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output tte_pkg::t_out_item     o_data
);

    import tte_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [AW:0] DEPTH_CNT = (AW + 1)'(TABLE_DEPTH);

    t_state      r_state, n_state;
    logic [AW:0] r_issue, n_issue;
    logic        r_chk_valid, n_chk_valid;
    logic [AW-1:0] r_chk_addr, n_chk_addr;
    logic [CW-1:0] r_removed, n_removed;
    logic [CW-1:0] r_occ, n_occ;
    logic        r_hit, n_hit;
    logic [AW-1:0] r_hit_addr, n_hit_addr;
    logic [15:0] r_hit_seq, n_hit_seq;
    logic        r_free_found, n_free_found;
    logic [AW-1:0] r_free_addr, n_free_addr;
    logic [31:0] r_time, n_time;
    logic [31:0] r_lorig, n_lorig;
    logic [15:0] r_lseq, n_lseq;
    logic [15:0] r_lhold, n_lhold;
    t_in_item    r_item, n_item;
    logic [2:0]  r_result_code, n_result_code;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    t_entry            mem_wentry;
    logic              mem_re;
    logic [ENTRY_W-1:0] mem_rdata;
    t_entry            rd_entry;
    t_eval             eval;
    logic [32:0]       exp_sum;
    logic [31:0]       expiry_now;

    tte_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_entry_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wentry),
        .i_re   (mem_re),
        .i_raddr(r_issue[AW-1:0]),
        .o_rdata(mem_rdata)
    );

    assign rd_entry = t_entry'(mem_rdata);

    tte_eval u_eval (
        .i_kind              (r_item.kind),
        .i_entry             (rd_entry),
        .i_originator        (r_item.originator),
        .i_seq_number        (r_item.seq_number),
        .i_selector_address  (r_item.selector_address),
        .i_latched_originator(r_lorig),
        .i_time              (r_time),
        .o_eval              (eval)
    );

    assign exp_sum    = {1'b0, r_time} + 33'(r_lhold);
    assign expiry_now = exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_comb begin
        n_state       = r_state;
        n_issue       = r_issue;
        n_chk_valid   = 1'b0;
        n_chk_addr    = r_issue[AW-1:0];
        n_removed     = r_removed;
        n_occ         = r_occ;
        n_hit         = r_hit;
        n_hit_addr    = r_hit_addr;
        n_hit_seq     = r_hit_seq;
        n_free_found  = r_free_found;
        n_free_addr   = r_free_addr;
        n_time        = r_time;
        n_lorig       = r_lorig;
        n_lseq        = r_lseq;
        n_lhold       = r_lhold;
        n_item        = r_item;
        n_result_code = r_result_code;
        n_out_valid   = r_out_valid && !i_ready;
        n_out         = r_out;
        mem_we        = 1'b0;
        mem_waddr     = r_issue[AW-1:0];
        mem_wentry    = '0;
        mem_re        = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (r_issue == DEPTH_CNT - 1'b1) begin
                    n_issue = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_issue = r_issue + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    n_item       = i_data;
                    n_issue      = '0;
                    n_removed    = '0;
                    n_hit        = 1'b0;
                    n_free_found = 1'b0;
                    n_state      = ST_SCAN;
                    unique case (i_data.kind)
                        KIND_HEADER: begin
                            n_lorig = i_data.originator;
                            n_lseq  = i_data.seq_number;
                            n_lhold = i_data.hold_ticks;
                        end
                        KIND_SELECTOR: ;
                        KIND_TICK: begin
                            if (r_time != 32'hFFFF_FFFF) begin
                                n_time = r_time + 32'd1;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_issue != DEPTH_CNT) begin
                    mem_re      = 1'b1;
                    n_chk_valid = 1'b1;
                    n_issue     = r_issue + 1'b1;
                end
                if (r_chk_valid) begin
                    if (eval.clear_entry) begin
                        mem_we           = 1'b1;
                        mem_waddr        = r_chk_addr;
                        mem_wentry       = rd_entry;
                        mem_wentry.valid = 1'b0;
                        n_removed        = r_removed + 1'b1;
                        n_occ            = r_occ - 1'b1;
                    end
                    if (eval.hit && !r_hit) begin
                        n_hit      = 1'b1;
                        n_hit_addr = r_chk_addr;
                        n_hit_seq  = rd_entry.seq;
                    end
                    if (eval.empty && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_addr  = r_chk_addr;
                    end
                end else if (r_issue == DEPTH_CNT) begin
                    n_state = (r_item.kind == KIND_SELECTOR) ? ST_UPDATE : ST_DONE;
                    n_result_code = (r_item.kind == KIND_TICK) ? STATUS_TICK_DONE
                                                               : STATUS_HEADER_DONE;
                end
            end
            ST_UPDATE: begin
                mem_wentry.valid    = 1'b1;
                mem_wentry.dest     = r_item.selector_address;
                mem_wentry.last_hop = r_lorig;
                mem_wentry.expiry   = expiry_now;
                if (r_hit) begin
                    mem_we           = 1'b1;
                    mem_waddr        = r_hit_addr;
                    mem_wentry.seq   = r_hit_seq;
                    n_result_code    = STATUS_REFRESHED;
                end else if (r_free_found) begin
                    mem_we           = 1'b1;
                    mem_waddr        = r_free_addr;
                    mem_wentry.seq   = r_lseq;
                    n_occ            = r_occ + 1'b1;
                    n_result_code    = STATUS_INSERTED;
                end else begin
                    n_result_code    = STATUS_DROPPED;
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid         = 1'b1;
                    n_out.status        = r_result_code;
                    n_out.removed_count = (32'(r_removed) > 32'd127) ? 7'd127
                                                                     : 7'(r_removed);
                    n_out.occupancy     = (32'(r_occ) > 32'd127) ? 7'd127 : 7'(r_occ);
                    n_state             = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_issue      <= '0;
            r_chk_valid  <= 1'b0;
            r_removed    <= '0;
            r_occ        <= '0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_time       <= '0;
            r_lorig      <= '0;
            r_lseq       <= '0;
            r_lhold      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_issue      <= n_issue;
            r_chk_valid  <= n_chk_valid;
            r_removed    <= n_removed;
            r_occ        <= n_occ;
            r_hit        <= n_hit;
            r_free_found <= n_free_found;
            r_time       <= n_time;
            r_lorig      <= n_lorig;
            r_lseq       <= n_lseq;
            r_lhold      <= n_lhold;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_addr    <= n_chk_addr;
        r_hit_addr    <= n_hit_addr;
        r_hit_seq     <= n_hit_seq;
        r_free_addr   <= n_free_addr;
        r_item        <= n_item;
        r_result_code <= n_result_code;
        r_out         <= n_out;
    end

`ifndef NO_ASSERTIONS
    a_occ_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_occ) <= TABLE_DEPTH)
        else $error("Occupancy exceeds the table depth.");

    a_scan_write_checked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && mem_we) |-> r_chk_valid)
        else $error("Scan wrote an entry that was not read back.");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_ready)
        else $error("Transaction accepted during the clearing pass.");

    a_update_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE) |=> (r_state == ST_DONE))
        else $error("Selector update did not finish in one cycle.");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_topology_table_engine_core.sv =====
// Testbench for the topology table engine core: directed and random traffic against a predictor.
`timescale 1ns / 1ps

module tb_topology_table_engine_core;

    import tte_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_ITEMS_PER_PHASE = 135;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    int sender_idle_pct    = 9;
    int receiver_stall_pct = 48;
    int items_accepted     = 0;
    int error_count        = 0;
    int cycle_count        = 0;

    logic        table_valid    [TABLE_DEPTH];
    logic [31:0] table_dest     [TABLE_DEPTH];
    logic [31:0] table_last_hop [TABLE_DEPTH];
    logic [15:0] table_seq      [TABLE_DEPTH];
    logic [31:0] table_expiry   [TABLE_DEPTH];
    logic [31:0] tick_time          = '0;
    logic [31:0] header_originator  = '0;
    logic [15:0] header_seq         = '0;
    logic [15:0] header_hold        = '0;

    logic [31:0] originator_pool [4];
    logic [31:0] address_pool    [16];

    t_out_item predicted_results [$];

    topology_table_engine_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_data  (in_item),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_data  (out_item)
    );

    always #6 clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_topology_table_engine_core failed");
            $finish;
        end
    end

    always @(negedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    always @(posedge clk) begin : result_check
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (predicted_results.size() == 0) begin
                $display("%0t: result with none expected, actual %p", $time, out_item);
                error_count++;
            end else begin
                want = predicted_results.pop_front();
                if (out_item.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, out_item.status);
                    error_count++;
                end
                if (out_item.removed_count !== want.removed_count) begin
                    $display("%0t: removed_count expected %0d actual %0d",
                             $time, want.removed_count, out_item.removed_count);
                    error_count++;
                end
                if (out_item.occupancy !== want.occupancy) begin
                    $display("%0t: occupancy expected %0d actual %0d",
                             $time, want.occupancy, out_item.occupancy);
                    error_count++;
                end
            end
        end
    end

    task automatic predict_table_update(input t_in_item item);
        int          hit;
        int          free_slot;
        logic [6:0]  removed;
        logic [6:0]  occupied;
        logic [32:0] expiry_sum;
        logic [31:0] new_expiry;
        t_out_item   result;
        hit        = -1;
        free_slot  = -1;
        removed    = '0;
        occupied   = '0;
        expiry_sum = {1'b0, tick_time} + {17'd0, header_hold};
        new_expiry = expiry_sum[32] ? 32'hFFFF_FFFF : expiry_sum[31:0];
        case (item.kind)
            KIND_HEADER: begin
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (table_valid[i] && table_last_hop[i] == item.originator &&
                        table_seq[i] < item.seq_number) begin
                        table_valid[i] = 1'b0;
                        removed++;
                    end
                end
                header_originator = item.originator;
                header_seq        = item.seq_number;
                header_hold       = item.hold_ticks;
                result.status     = STATUS_HEADER_DONE;
            end
            KIND_SELECTOR: begin
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (table_valid[i]) begin
                        if (hit < 0 && table_dest[i] == item.selector_address &&
                            table_last_hop[i] == header_originator)
                            hit = i;
                    end else if (free_slot < 0) begin
                        free_slot = i;
                    end
                end
                if (hit >= 0) begin
                    table_expiry[hit] = new_expiry;
                    result.status     = STATUS_REFRESHED;
                end else if (free_slot >= 0) begin
                    table_valid[free_slot]    = 1'b1;
                    table_dest[free_slot]     = item.selector_address;
                    table_last_hop[free_slot] = header_originator;
                    table_seq[free_slot]      = header_seq;
                    table_expiry[free_slot]   = new_expiry;
                    result.status             = STATUS_INSERTED;
                end else begin
                    result.status = STATUS_DROPPED;
                end
            end
            KIND_TICK: begin
                if (tick_time != 32'hFFFF_FFFF)
                    tick_time = tick_time + 32'd1;
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (table_valid[i] && table_expiry[i] < tick_time) begin
                        table_valid[i] = 1'b0;
                        removed++;
                    end
                end
                result.status = STATUS_TICK_DONE;
            end
            default: return;
        endcase
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (table_valid[i])
                occupied++;
        end
        result.removed_count = removed;
        result.occupancy     = occupied;
        predicted_results.insert(predicted_results.size(), result);
    endtask

    task automatic send_item(input t_in_item item);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (!in_ready);
        predict_table_update(item);
        if (item.kind != KIND_UNUSED)
            items_accepted++;
    endtask

    function automatic t_in_item random_item();
        t_in_item item;
        item.kind             = 2'($urandom_range(0, 3));
        item.originator       = $urandom;
        item.seq_number       = 16'($urandom);
        item.hold_ticks       = 16'($urandom);
        item.selector_address = $urandom;
        return item;
    endfunction

    function automatic t_in_item make_header(input logic [31:0] originator,
                                             input logic [15:0] seq_number,
                                             input logic [15:0] hold_ticks);
        t_in_item item;
        item            = random_item();
        item.kind       = KIND_HEADER;
        item.originator = originator;
        item.seq_number = seq_number;
        item.hold_ticks = hold_ticks;
        return item;
    endfunction

    function automatic t_in_item make_selector(input logic [31:0] address);
        t_in_item item;
        item                  = random_item();
        item.kind             = KIND_SELECTOR;
        item.selector_address = address;
        return item;
    endfunction

    function automatic t_in_item make_tick();
        t_in_item item;
        item      = random_item();
        item.kind = KIND_TICK;
        return item;
    endfunction

    task automatic test_selector_before_header();
        send_item(make_selector(32'h0000_0000));
        send_item(make_selector(32'h0000_0000));
        send_item(make_tick());
    endtask

    task automatic test_field_extremes();
        send_item(make_header(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
        send_item(make_selector(32'hFFFF_FFFF));
        send_item(make_selector(32'h0000_0000));
        send_item(make_header(32'hFFFF_FFFF, 16'hFFFF, 16'h0000));
        send_item(make_header(32'hFFFF_FFFF, 16'h0001, 16'h0000));
        send_item(make_selector(32'hFFFF_FFFF));
        send_item(make_tick());
        send_item(make_header(32'h0000_0000, 16'h0000, 16'hFFFF));
        send_item(make_selector(32'hA5A5_5A5A));
        send_item(make_header(32'h0000_0000, 16'hFFFF, 16'h0007));
        send_item(make_tick());
    endtask

    task automatic test_unused_kind();
        t_in_item item;
        item      = '1;
        send_item(item);
        item      = random_item();
        item.kind = KIND_UNUSED;
        send_item(item);
        send_item(make_tick());
    endtask

    task automatic test_table_full();
        logic [31:0] originator;
        originator = $urandom;
        send_item(make_header(originator, 16'h0000, 16'd4));
        repeat (TABLE_DEPTH + 4) send_item(make_selector($urandom));
        send_item(make_header(originator, 16'hFFFF, 16'($urandom)));
        repeat (6) send_item(make_tick());
    endtask

    function automatic logic [31:0] pick_originator();
        return ($urandom_range(0, 9) < 8) ? originator_pool[$urandom_range(0, 3)] : $urandom;
    endfunction

    function automatic logic [31:0] pick_address();
        return ($urandom_range(0, 9) < 8) ? address_pool[$urandom_range(0, 15)] : $urandom;
    endfunction

    function automatic logic [15:0] pick_hold();
        return ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
    endfunction

    task automatic test_random_traffic(input int count);
        int target;
        target = items_accepted + count;
        while (items_accepted < target) begin
            if ($urandom_range(0, 99) < 85) begin
                send_item(make_header(pick_originator(), 16'($urandom), pick_hold()));
                repeat ($urandom_range(1, 8)) send_item(make_selector(pick_address()));
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3)) send_item(make_tick());
            end else begin
                send_item(random_item());
            end
        end
    endtask

    initial begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            table_valid[i]    = 1'b0;
            table_dest[i]     = '0;
            table_last_hop[i] = '0;
            table_seq[i]      = '0;
            table_expiry[i]   = '0;
        end
        for (int i = 0; i < 4; i++)
            originator_pool[i] = $urandom;
        for (int i = 0; i < 16; i++)
            address_pool[i] = $urandom;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_selector_before_header();
        test_field_extremes();
        test_unused_kind();

        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct    = (phase == 0) ? 9 : (phase == 1) ? 48 : 0;
            receiver_stall_pct = (phase == 0) ? 48 : (phase == 1) ? 9 : 0;
            test_table_full();
            test_random_traffic(RANDOM_ITEMS_PER_PHASE);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        wait (predicted_results.size() == 0);
        repeat (TABLE_DEPTH + 16) @(posedge clk);

        if (error_count == 0) begin
            $display("tb_topology_table_engine_core passed");
        end else begin
            $display("tb_topology_table_engine_core failed");
        end
        $finish;
    end

endmodule

// ===== topology_table_engine_core.f =====
src/tte_pkg.sv
src/tte_ram.sv
src/tte_eval.sv
src/topology_table_engine_core.sv
sim/tb_topology_table_engine_core.sv
